### hw/rtl/elc_pkg.sv
// shared constants, register codes and state type for the expert lookup cache
package elc_pkg;

	localparam int ELC_CACHE_ENTRIES = 8;
	localparam int ELC_MAX_EXPERTS = 256;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 9;
	localparam int EXPERT_ID_W = 8;
	localparam int TOTAL_W = 32;

	localparam logic [8:0] EXPERT_COUNT_RST = 9'd8;
	localparam logic [3:0] CACHE_CAPACITY_RST = 4'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EXPERT_COUNT = 2'd0,
		CFG_CACHE_CAPACITY = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic scan_issue;
		logic scan_last;
		logic commit;
	} ctrl_t;

endpackage

### hw/rtl/expert_lookup_lru_cache.sv
// Fully associative LRU cache for expert ids. An item goes through an accept state
// (ST_IDLE), a scan state in which the tag RAM is read one entry a cycle through a single
// compare unit that looks for the match, the first free slot and the oldest entry, and an
// update state. An id at or above the expert count or MAX_EXPERTS skips the scan. The
// update state waits while the previous result is still held on the output. A new item
// is taken only in the idle state. Configuration is taken at any time
// (cfg_ready is always high) but is only meant to change while the block is idle.
module expert_lookup_lru_cache import elc_pkg::*; #(
	parameter int CACHE_ENTRIES = ELC_CACHE_ENTRIES,
	parameter int MAX_EXPERTS = ELC_MAX_EXPERTS
) (
	input  logic clk,
	input  logic arst_n,

	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic in_valid,
	output logic in_ready,
	input  logic [EXPERT_ID_W-1:0] req_id,

	output logic out_valid,
	input  logic out_ready,
	output logic rejected,
	output logic hit,
	output logic evicted_valid,
	output logic [EXPERT_ID_W-1:0] evicted_id,
	output logic [TOTAL_W-1:0] hit_total,
	output logic [TOTAL_W-1:0] miss_total
);

	localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
	localparam int CAP_W = (CNT_W > 4) ? CNT_W : 4;
	localparam int LIM_W = ($clog2(MAX_EXPERTS + 1) > CFG_DATA_W) ?
		$clog2(MAX_EXPERTS + 1) : CFG_DATA_W;

	state_t state_q, state_d;
	ctrl_t ctrl;

	logic [8:0] expert_count_q;
	logic [3:0] cache_capacity_q;

	logic [EXPERT_ID_W-1:0] id_q;
	logic rej_q;
	logic [CNT_W-1:0] scan_cnt_q;
	logic cmp_v_s1;
	logic [IDX_W-1:0] cmp_idx_s1;

	logic [CACHE_ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0] rec_q [CACHE_ENTRIES];

	logic found_v_q;
	logic [IDX_W-1:0] found_idx_q;
	logic [IDX_W-1:0] found_rec_q;
	logic free_v_q;
	logic [IDX_W-1:0] free_idx_q;
	logic victim_v_q;
	logic [IDX_W-1:0] victim_idx_q;
	logic [IDX_W-1:0] victim_rec_q;
	logic [EXPERT_ID_W-1:0] victim_tag_q;
	logic [CNT_W-1:0] used_q;

	logic [TOTAL_W-1:0] hit_cnt_q, miss_cnt_q;

	logic out_valid_q;
	logic rejected_q, hit_q, evicted_valid_q;
	logic [EXPERT_ID_W-1:0] evicted_id_q;
	logic [TOTAL_W-1:0] hit_total_q, miss_total_q;

	logic in_acc;
	logic id_rej;
	logic [EXPERT_ID_W-1:0] tag_rd;
	logic ent_valid;
	logic [IDX_W-1:0] ent_rec;
	logic [CAP_W-1:0] cap_ext, cap_eff;
	logic use_free;
	logic [IDX_W-1:0] slot;
	logic do_hit, do_miss;
	logic [TOTAL_W-1:0] hit_cnt_d, miss_cnt_d;
	logic tag_wr_en;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expert_count_q <= EXPERT_COUNT_RST;
			cache_capacity_q <= CACHE_CAPACITY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_EXPERT_COUNT: begin
					expert_count_q <= cfg_data[8:0];
				end
				CFG_CACHE_CAPACITY: begin
					cache_capacity_q <= cfg_data[3:0];
				end
				default: begin
				end
			endcase
		end
	end

	// sequencer
	assign in_acc = in_valid && ctrl.in_ready;
	assign id_rej = (LIM_W'(req_id) >= LIM_W'(expert_count_q)) ||
		(LIM_W'(req_id) >= LIM_W'(MAX_EXPERTS));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = id_rej ? ST_UPDATE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (ctrl.scan_last) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (ctrl.commit) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.in_ready = 1'b1;
			end
			ST_SCAN: begin
				ctrl.scan_issue = scan_cnt_q < CNT_W'(CACHE_ENTRIES);
				ctrl.scan_last = scan_cnt_q == CNT_W'(CACHE_ENTRIES);
			end
			ST_UPDATE: begin
				ctrl.commit = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_cnt_q <= '0;
			cmp_v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			cmp_v_s1 <= ctrl.scan_issue;
			if (in_acc) begin
				scan_cnt_q <= '0;
			end else if (ctrl.scan_issue) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			id_q <= req_id;
			rej_q <= id_rej;
		end
		cmp_idx_s1 <= scan_cnt_q[IDX_W-1:0];
	end

	// tag store
	elc_ram #(
		.WIDTH(EXPERT_ID_W),
		.DEPTH(CACHE_ENTRIES)
	) u_tag_ram (
		.clk(clk),
		.wr_en(tag_wr_en),
		.wr_addr(slot),
		.wr_data(id_q),
		.rd_addr(scan_cnt_q[IDX_W-1:0]),
		.rd_data(tag_rd)
	);

	// shared compare unit, one entry a cycle
	assign ent_valid = valid_q[cmp_idx_s1];
	assign ent_rec = rec_q[cmp_idx_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_v_q <= 1'b0;
			free_v_q <= 1'b0;
			victim_v_q <= 1'b0;
			used_q <= '0;
		end else if (in_acc) begin
			found_v_q <= 1'b0;
			free_v_q <= 1'b0;
			victim_v_q <= 1'b0;
			used_q <= '0;
		end else if (cmp_v_s1) begin
			if (ent_valid) begin
				used_q <= used_q + 1'b1;
				if (!found_v_q && tag_rd == id_q) begin
					found_v_q <= 1'b1;
				end
				if (!victim_v_q || ent_rec > victim_rec_q) begin
					victim_v_q <= 1'b1;
				end
			end else if (!free_v_q) begin
				free_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_v_s1) begin
			if (ent_valid) begin
				if (!found_v_q && tag_rd == id_q) begin
					found_idx_q <= cmp_idx_s1;
					found_rec_q <= ent_rec;
				end
				if (!victim_v_q || ent_rec > victim_rec_q) begin
					victim_idx_q <= cmp_idx_s1;
					victim_rec_q <= ent_rec;
					victim_tag_q <= tag_rd;
				end
			end else if (!free_v_q) begin
				free_idx_q <= cmp_idx_s1;
			end
		end
	end

	// update step
	always_comb begin
		cap_ext = CAP_W'(cache_capacity_q);
		if (cap_ext == '0) begin
			cap_eff = CAP_W'(1);
		end else if (cap_ext > CAP_W'(CACHE_ENTRIES)) begin
			cap_eff = CAP_W'(CACHE_ENTRIES);
		end else begin
			cap_eff = cap_ext;
		end
	end

	assign use_free = free_v_q && (CAP_W'(used_q) < cap_eff);
	assign slot = use_free ? free_idx_q : victim_idx_q;
	assign do_hit = ctrl.commit && !rej_q && found_v_q;
	assign do_miss = ctrl.commit && !rej_q && !found_v_q;
	assign tag_wr_en = do_miss;
	assign hit_cnt_d = hit_cnt_q + TOTAL_W'(do_hit);
	assign miss_cnt_d = miss_cnt_q + TOTAL_W'(do_miss);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_cnt_q <= '0;
			miss_cnt_q <= '0;
		end else begin
			hit_cnt_q <= hit_cnt_d;
			miss_cnt_q <= miss_cnt_d;
			if (do_miss) begin
				valid_q[slot] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CACHE_ENTRIES; i++) begin
			if (do_hit) begin
				if (IDX_W'(i) == found_idx_q) begin
					rec_q[i] <= '0;
				end else if (valid_q[i] && rec_q[i] < found_rec_q) begin
					rec_q[i] <= rec_q[i] + 1'b1;
				end
			end else if (do_miss) begin
				if (IDX_W'(i) == slot) begin
					rec_q[i] <= '0;
				end else if (valid_q[i]) begin
					rec_q[i] <= rec_q[i] + 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			rejected_q <= rej_q;
			hit_q <= do_hit;
			evicted_valid_q <= do_miss && !use_free;
			evicted_id_q <= (do_miss && !use_free) ? victim_tag_q : '0;
			hit_total_q <= hit_cnt_d;
			miss_total_q <= miss_cnt_d;
		end
	end

	assign in_ready = ctrl.in_ready;
	assign out_valid = out_valid_q;
	assign rejected = rejected_q;
	assign hit = hit_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_id = evicted_id_q;
	assign hit_total = hit_total_q;
	assign miss_total = miss_total_q;

endmodule

### hw/rtl/elc_ram.sv
// generic single write port ram with registered read
module elc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic clk,
	input  logic wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### hw/rtl/elc_checker.sv
// port level checks for the expert lookup cache, bound to the top level
module elc_checker import elc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic rejected,
	input logic hit,
	input logic evicted_valid,
	input logic [EXPERT_ID_W-1:0] evicted_id,
	input logic [TOTAL_W-1:0] hit_total,
	input logic [TOTAL_W-1:0] miss_total
);

	// a rejected item leaves every other flag clear
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> !hit && !evicted_valid && evicted_id == '0)
		else $error("rejected item with hit or eviction");

	// an eviction only comes with a miss
	a_evict_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted_valid |-> !hit && !rejected)
		else $error("eviction reported on hit or rejected item");

	// one item at a time
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

	// a stalled result holds its totals
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit_total) && $stable(miss_total))
		else $error("stalled result changed");

endmodule

bind expert_lookup_lru_cache elc_checker u_elc_checker (.*);
